// ===== src/oal_pkg.sv =====
// Shared types and constants for the ordered array list engine.
// No dependencies; oal_cell and the top level import this package.
package oal_pkg;

    localparam int WORD_W = 32;
    localparam int SUM_W  = 38;
    localparam int CNT_W  = 7;
    localparam int POS_W  = 6;
    localparam int MODE_W = 3;

    typedef logic signed [WORD_W-1:0] t_word;

    // Request modes; code 7 is unused and behaves as a query
    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_INSERT = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_EDIT   = 3'd3,
        MODE_READ   = 3'd4,
        MODE_SEARCH = 3'd5,
        MODE_QUERY  = 3'd6
    } t_mode;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } t_state;

    // What every cell does to its word in the update cycle
    typedef enum logic [1:0] {
        CMD_HOLD,
        CMD_PUT,
        CMD_INSERT,
        CMD_DELETE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [CNT_W-1:0] pos;
        t_word            data;
    } t_cmd;

    // Broadcast to the cells while the reduction wave runs
    typedef struct packed {
        t_word            key;
        logic [CNT_W-1:0] rd_pos;
        logic [CNT_W-1:0] count;
    } t_scan;

    // Running reduction handed from cell to cell
    typedef struct packed {
        logic                    any;
        logic signed [SUM_W-1:0] sum;
        t_word                   max_w;
        t_word                   min_w;
        logic                    found_v;
        logic [CNT_W-1:0]        found_idx;
        t_word                   rd;
    } t_part;

    localparam t_part PART_EMPTY = '{
        any:       1'b0,
        sum:       '0,
        max_w:     '0,
        min_w:     '0,
        found_v:   1'b0,
        found_idx: '0,
        rd:        '0
    };

    localparam t_word            WORD_NONE  = -1;
    localparam logic [CNT_W-1:0] INDEX_NONE = '1;

endpackage

// ===== src/oal_if.sv =====
// Request and response channel interfaces (valid/ready handshake).
// No dependencies.
interface oal_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         mode;
    logic [5:0]         position;
    logic signed [31:0] data_value;

    modport source (output valid, mode, position, data_value, input ready);
    modport sink   (input valid, mode, position, data_value, output ready);
endinterface

interface oal_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic signed [6:0]  found_index;
    logic [6:0]         element_total;
    logic signed [37:0] sum_value;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;
    logic               is_full;
    logic               is_empty;

    modport source (output valid, status, read_value, found_index, element_total,
                    sum_value, max_value, min_value, is_full, is_empty, input ready);
    modport sink   (input valid, status, read_value, found_index, element_total,
                    sum_value, max_value, min_value, is_full, is_empty, output ready);
endinterface

// ===== src/oal_cell.sv =====
// One slot of the list: holds a word, shifts with its neighbors and folds
// its word into the running reduction passed down the chain. Uses oal_pkg.
module oal_cell
    import oal_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic  i_clk,
    input  t_cmd  i_cmd,
    input  t_word i_left,
    input  t_word i_right,
    input  t_scan i_scan,
    input  t_part i_part,
    output t_word o_word,
    output t_part o_part
);

    t_word r_word;
    t_word n_word;
    t_part r_part;
    t_part n_part;
    logic  active;

    // Word update: write, shift right on insert, shift left on delete
    always_comb begin
        n_word = r_word;
        unique case (i_cmd.kind)
            CMD_HOLD: begin
            end
            CMD_PUT: begin
                if (int'(i_cmd.pos) == INDEX) n_word = i_cmd.data;
            end
            CMD_INSERT: begin
                if (INDEX > int'(i_cmd.pos)) n_word = i_left;
                else if (INDEX == int'(i_cmd.pos)) n_word = i_cmd.data;
            end
            CMD_DELETE: begin
                if (INDEX >= int'(i_cmd.pos)) n_word = i_right;
            end
            default: begin
            end
        endcase
    end

    // Fold this slot into the reduction; slots past the count pass through
    always_comb begin
        active = INDEX < int'(i_scan.count);
        n_part = i_part;
        if (active) begin
            n_part.any = 1'b1;
            n_part.sum = i_part.sum + SUM_W'(r_word);
            if (!i_part.any || r_word > i_part.max_w) n_part.max_w = r_word;
            if (!i_part.any || r_word < i_part.min_w) n_part.min_w = r_word;
            if (!i_part.found_v && r_word == i_scan.key) begin
                n_part.found_v   = 1'b1;
                n_part.found_idx = CNT_W'(INDEX);
            end
            if (int'(i_scan.rd_pos) == INDEX) n_part.rd = r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_part <= n_part;
    end

    assign o_word = r_word;
    assign o_part = r_part;

endmodule

// ===== src/ordered_array_list_engine.sv =====
// Top level of the ordered array list engine: control, status and the cell chain.
// Uses oal_pkg, oal_req_if, oal_rsp_if and oal_cell.
//
// Usage:
//   i_req carries one request (mode, position, data_value); it is taken when
//   valid and ready are both high. o_rsp returns exactly one response per
//   request with status, read word or found index, and count, sum, max, min,
//   full and empty as they stand after the request.
//   i_cfg_we/i_cfg_data write the capacity (clamped to DEPTH) and empty the
//   list; write it only while no request is in flight.
// Timing:
//   The update state applies the edit to all cells at once (shifts included),
//   then a reduction wave walks the chain one cell per cycle, and the response
//   is loaded once the wave has left the last cell. One request is handled
//   at a time: the next is taken only after the earlier one has walked the
//   whole cell chain and its response has been loaded.
// Reset and stalls:
//   Synchronous active-low reset empties the list and sets capacity to 0.
//   The response sits in an output register; the next request can be taken
//   while it waits, and that request holds in its final cycle until the
//   receiver takes the earlier response.
module ordered_array_list_engine
    import oal_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    oal_req_if.sink          i_req,
    oal_rsp_if.source        o_rsp
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(DEPTH - 1);

    // Control state
    t_state           r_state;
    t_state           n_state;
    logic [IDX_W-1:0] r_scan;
    logic [IDX_W-1:0] n_scan;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] n_cap;
    logic             r_out_valid;
    logic             load_out;
    logic             req_take;

    // Request and response payload
    t_mode            r_mode;
    logic [POS_W-1:0] r_pos;
    t_word            r_data;
    t_status          r_status;
    t_status          n_status;
    t_status          r_out_status;
    t_word            r_out_read;
    logic [CNT_W-1:0] r_out_found;
    logic [CNT_W-1:0] r_out_total;
    logic signed [SUM_W-1:0] r_out_sum;
    t_word            r_out_max;
    t_word            r_out_min;
    logic             r_out_full;
    logic             r_out_empty;

    t_cmd             cmd;
    t_scan            scan;
    logic [CNT_W-1:0] pos_ext;
    logic             list_full;
    logic             list_empty;
    t_part            last;

    t_word            cell_word  [DEPTH];
    t_word            cell_left  [DEPTH];
    t_word            cell_right [DEPTH];
    t_part            cell_part  [DEPTH];
    t_part            cell_pin   [DEPTH];

    assign req_take    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);

    // Clamp capacity to the store depth
    always_comb begin
        if (int'(i_cfg_data) > DEPTH) n_cap = CNT_W'(DEPTH);
        else n_cap = i_cfg_data;
    end

    // Status, new count and cell command for the update cycle
    always_comb begin
        pos_ext    = {1'b0, r_pos};
        list_full  = r_count >= r_cap;
        list_empty = r_count == '0;
        n_status   = STATUS_OK;
        n_count    = r_count;
        cmd        = '{kind: CMD_HOLD, pos: pos_ext, data: r_data};
        unique case (r_mode)
            MODE_APPEND: begin
                if (list_full) n_status = STATUS_FULL;
                else begin
                    cmd.kind = CMD_PUT;
                    cmd.pos  = r_count;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_INSERT: begin
                if (list_full) n_status = STATUS_FULL;
                else if (pos_ext > r_count) n_status = STATUS_BADPOS;
                else begin
                    cmd.kind = CMD_INSERT;
                    n_count  = r_count + 1'b1;
                end
            end
            MODE_DELETE: begin
                if (list_empty) n_status = STATUS_EMPTY;
                else if (pos_ext >= r_count) n_status = STATUS_BADPOS;
                else begin
                    cmd.kind = CMD_DELETE;
                    n_count  = r_count - 1'b1;
                end
            end
            MODE_EDIT: begin
                if (list_empty) n_status = STATUS_EMPTY;
                else if (pos_ext >= r_count) n_status = STATUS_BADPOS;
                else cmd.kind = CMD_PUT;
            end
            MODE_READ: begin
                if (list_empty) n_status = STATUS_EMPTY;
                else if (pos_ext >= r_count) n_status = STATUS_BADPOS;
            end
            default: begin
            end
        endcase
        if (r_state != ST_EXEC) cmd.kind = CMD_HOLD;
    end

    assign scan = '{key: r_data, rd_pos: pos_ext, count: r_count};

    // Sequencer: update, walk the chain, hand off the response
    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        n_scan   = (r_state == ST_SCAN) ? r_scan + 1'b1 : '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_scan == SCAN_LAST) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_scan      <= '0;
            r_count     <= '0;
            r_cap       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_scan  <= n_scan;
            if (i_cfg_we) begin
                r_cap   <= n_cap;
                r_count <= '0;
            end else if (r_state == ST_EXEC) begin
                r_count <= n_count;
            end
            if (load_out) r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_mode <= t_mode'(i_req.mode);
            r_pos  <= i_req.position;
            r_data <= i_req.data_value;
        end
        if (r_state == ST_EXEC) r_status <= n_status;
        if (load_out) begin
            r_out_status <= r_status;
            r_out_read   <= (r_mode == MODE_READ && r_status == STATUS_OK) ?
                            last.rd : WORD_NONE;
            r_out_found  <= (r_mode == MODE_SEARCH && last.found_v) ?
                            last.found_idx : INDEX_NONE;
            r_out_total  <= r_count;
            r_out_sum    <= last.sum;
            r_out_max    <= last.max_w;
            r_out_min    <= last.min_w;
            r_out_full   <= r_count >= r_cap;
            r_out_empty  <= r_count == '0;
        end
    end

    // Cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign cell_left[g] = '0;
            assign cell_pin[g]  = PART_EMPTY;
        end else begin : g_body
            assign cell_left[g] = cell_word[g-1];
            assign cell_pin[g]  = cell_part[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign cell_right[g] = cell_word[g];
        end else begin : g_inner
            assign cell_right[g] = cell_word[g+1];
        end

        oal_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (cell_left[g]),
            .i_right (cell_right[g]),
            .i_scan  (scan),
            .i_part  (cell_pin[g]),
            .o_word  (cell_word[g]),
            .o_part  (cell_part[g])
        );
    end

    assign last = cell_part[DEPTH-1];

    // Response port
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.read_value    = r_out_read;
    assign o_rsp.found_index   = r_out_found;
    assign o_rsp.element_total = r_out_total;
    assign o_rsp.sum_value     = r_out_sum;
    assign o_rsp.max_value     = r_out_max;
    assign o_rsp.min_value     = r_out_min;
    assign o_rsp.is_full       = r_out_full;
    assign o_rsp.is_empty      = r_out_empty;

    // Checks
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_cap)
        else $error("element count above capacity");

    a_take_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> r_state == ST_EXEC)
        else $error("taken request did not start update");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_DONE)
        else $error("response raised outside final step");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> ($past(r_state) == ST_EXEC || $past(i_cfg_we)))
        else $error("count changed outside update or capacity write");

endmodule
